@@ hdl/fxmd_pkg.sv @@
// ----------------------------------------------------------------------------
// fxmd_pkg: shared types and constants for the fixed-point multiply/divide
// Operation codes, widths and the request/result structs.
// ----------------------------------------------------------------------------
`default_nettype none
package fxmd_pkg;
	localparam int FRAC_BITS   = 16;
	localparam int GUARD_SHIFT = 30 - FRAC_BITS;
	localparam int DW          = 32;
	localparam int QW          = DW + FRAC_BITS;
	localparam int QDEPTH      = 4;
	localparam int QAW         = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		OP_MUL   = 2'd0,
		OP_MULSH = 2'd1,
		OP_DIV   = 2'd2,
		OP_SCALE = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]           req_type;
		logic signed [DW-1:0] operand_a;
		logic signed [DW-1:0] operand_b;
		logic signed [DW-1:0] operand_c;
		logic [5:0]           shift_amount;
	} req_t;

	typedef struct packed {
		logic signed [DW-1:0] result;
		logic                 saturated;
	} rsp_t;

	// classified request passed from front to back
	typedef struct packed {
		logic                 is_div;    // needs a divide at the end
		logic                 pre_mul;   // divide input comes from a product
		logic [5:0]           shift;
		logic signed [DW-1:0] a;
		logic signed [DW-1:0] b;
		logic signed [DW-1:0] c;
	} cmd_t;

	function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
		return v[DW-1] ? (~v + 1'b1) : v;
	endfunction
endpackage
`default_nettype wire

@@ hdl/fxmd_if.sv @@
// ----------------------------------------------------------------------------
// fxmd_req_if / fxmd_rsp_if: valid/ready channels
// One interface per payload type, each with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none
interface fxmd_req_if import fxmd_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fxmd_rsp_if import fxmd_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/fixed_point_mul_div.sv @@
// ----------------------------------------------------------------------------
// fixed_point_mul_div: signed 16.16 multiply, shift, divide and scale
// Front end queues classified requests; back end runs a fixed pipeline.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   req_type, operand_a, operand_b, operand_c, shift_amount
//  rsp      out  result, saturated
//
// One request per cycle sustained while the output is not held. After its
// request is taken, a result passes the 4-entry queue, then multiply,
// shift/setup, 48 quotient-bit stages and the output register. The whole
// back pipeline stalls when the output is held; the queue then fills and
// drops req.ready. Reset clears all valid state.
`default_nettype none
module fixed_point_mul_div import fxmd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	fxmd_req_if.sink   req,
	fxmd_rsp_if.source rsp
);
	cmd_t cmd;
	logic cmd_valid, cmd_ready;

	fxmd_front u_front (
		.clk, .arst_n, .req,
		.cmd, .cmd_valid, .cmd_ready
	);

	fxmd_back u_back (
		.clk, .arst_n,
		.cmd, .cmd_valid, .cmd_ready,
		.rsp
	);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("response changed while stalled");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready && cmd_valid |=> cmd_valid)
		else $error("queue lost a command under stall");
	a_mulsat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.saturated |-> (rsp.data.result[30:0] == '0
			|| rsp.data.result[30:0] == '1))
		else $error("saturated result not at a limit");
endmodule
`default_nettype wire

@@ hdl/fxmd_front.sv @@
// ----------------------------------------------------------------------------
// fxmd_front: request classification and command queue
// Decodes the operation into a command and buffers it for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module fxmd_front import fxmd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	fxmd_req_if.sink  req,
	output cmd_t      cmd,
	output logic      cmd_valid,
	input  wire logic cmd_ready
);
	cmd_t             mem_q [QDEPTH];
	logic [QAW-1:0]   wptr_q, rptr_q;
	logic [QAW:0]     cnt_q;
	cmd_t             dec;
	logic             push, pop;

	always_comb begin
		dec.a       = req.data.operand_a;
		dec.b       = req.data.operand_b;
		dec.c       = req.data.operand_c;
		dec.shift   = 6'(FRAC_BITS);
		dec.is_div  = 1'b0;
		dec.pre_mul = 1'b1;
		case (op_t'(req.data.req_type))
			OP_MUL: ;
			OP_MULSH: dec.shift = req.data.shift_amount;
			OP_DIV: begin
				dec.is_div  = 1'b1;
				dec.pre_mul = 1'b0;
			end
			OP_SCALE: dec.is_div = 1'b1;
			default: ;
		endcase
	end

	assign req.ready = (cnt_q != (QAW+1)'(QDEPTH));
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

@@ hdl/fxmd_back.sv @@
// ----------------------------------------------------------------------------
// fxmd_back: multiply and restoring-divide pipeline
// Stage 1 multiplies, stage 2 shifts and sets up the divide, then one
// quotient bit per stage, then sign fix and an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module fxmd_back import fxmd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	fxmd_rsp_if.source rsp
);
	localparam int NST = QW;   // one quotient bit per stage

	// pipeline advances as a whole; the output register holds under stall
	logic adv;

	// stage 1: product
	logic                   v_s1, div_s1, pm_s1;
	logic [5:0]             sh_s1;
	logic signed [2*DW-1:0] p_s1;
	logic [DW-1:0]          a_s1, b_s1, c_s1;

	// stage 2: shifted value and divide setup
	logic                   v_s2, div_s2, sat_s2, neg_s2;
	logic [DW-1:0]          val_s2, mb_s2;
	logic [QW-1:0]          num_s2;

	logic [DW-1:0]          x_m, y_m, ma_m, mb_m;
	logic [2*DW-1:0]        sh_m;

	// divide stages
	logic          v_d   [NST+1];
	logic          div_d [NST+1];
	logic          sat_d [NST+1];
	logic          neg_d [NST+1];
	logic [DW-1:0] val_d [NST+1];
	logic [DW-1:0] mb_d  [NST+1];
	logic [QW-1:0] num_d [NST+1];
	logic [DW:0]   rem_d [NST+1];

	rsp_t out_q;
	logic out_v_q;

	assign adv       = !out_v_q || rsp.ready;
	assign cmd_ready = adv;

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s1 <= cmd.is_div;
			pm_s1  <= cmd.pre_mul;
			sh_s1  <= cmd.shift;
			p_s1   <= cmd.a * cmd.b;
			a_s1   <= cmd.a;
			b_s1   <= cmd.b;
			c_s1   <= cmd.c;
		end
	end

	always_comb begin
		sh_m = 64'($signed(p_s1) >>> sh_s1);
		x_m  = pm_s1 ? sh_m[DW-1:0] : a_s1;
		y_m  = pm_s1 ? c_s1 : b_s1;
		ma_m = mag(x_m);
		mb_m = mag(y_m);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s2 <= div_s1;
			neg_s2 <= x_m[DW-1] ^ y_m[DW-1];
			sat_s2 <= div_s1 && ((ma_m >> GUARD_SHIFT) >= mb_m);
			val_s2 <= x_m;
			mb_s2  <= mb_m;
			num_s2 <= {ma_m, {FRAC_BITS{1'b0}}};
		end
	end

	always_comb begin
		v_d[0]   = v_s2;
		div_d[0] = div_s2;
		sat_d[0] = sat_s2;
		neg_d[0] = neg_s2;
		val_d[0] = val_s2;
		mb_d[0]  = mb_s2;
		num_d[0] = num_s2;
		rem_d[0] = '0;
	end

	// num holds remaining dividend bits on top, quotient bits shift in below
	for (genvar i = 0; i < NST; i++) begin : g_div
		logic [DW:0] t;
		assign t = {rem_d[i][DW-1:0], num_d[i][QW-1]};
		always_ff @(posedge clk) begin
			if (adv) begin
				div_d[i+1] <= div_d[i];
				sat_d[i+1] <= sat_d[i];
				neg_d[i+1] <= neg_d[i];
				val_d[i+1] <= val_d[i];
				mb_d[i+1]  <= mb_d[i];
				if (t >= {1'b0, mb_d[i]}) begin
					rem_d[i+1] <= t - {1'b0, mb_d[i]};
					num_d[i+1] <= {num_d[i][QW-2:0], 1'b1};
				end else begin
					rem_d[i+1] <= t;
					num_d[i+1] <= {num_d[i][QW-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_d[i+1] <= 1'b0;
			else if (adv) v_d[i+1] <= v_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= cmd_valid;
			v_s2    <= v_s1;
			out_v_q <= v_d[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!div_d[NST]) begin
				out_q.result    <= val_d[NST];
				out_q.saturated <= 1'b0;
			end else if (sat_d[NST]) begin
				out_q.result    <= neg_d[NST] ? {1'b1, {(DW-1){1'b0}}}
				                              : {1'b0, {(DW-1){1'b1}}};
				out_q.saturated <= 1'b1;
			end else begin
				out_q.result    <= neg_d[NST] ? (~num_d[NST][DW-1:0] + 1'b1)
				                              : num_d[NST][DW-1:0];
				out_q.saturated <= 1'b0;
			end
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;
endmodule
`default_nettype wire

@@ tb/fixed_point_mul_div_tb.sv @@
// ----------------------------------------------------------------------------
// fixed_point_mul_div_tb: self-checking bench for the 16.16 multiply/divide
// Drives random and corner requests with random idling on both channels and
// compares every result against an in-bench arithmetic model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_mul_div_tb import fxmd_pkg::*;;

	localparam int LATENCY   = 60;
	localparam int WD_LIMIT  = 20000;
	localparam int N_RANDOM  = 1700;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   n_err = 0;
	int   idle_cycles = 0;
	bit   no_idle = 1'b0;
	bit   hold_rsp = 1'b0;

	fxmd_req_if req ();
	fxmd_rsp_if rsp ();

	fixed_point_mul_div u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always #2 clk = ~clk;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		$display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
		n_err++;
	endtask

	function automatic logic [31:0] magnitude(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	function automatic logic [31:0] product_shift(input logic [31:0] a, input logic [31:0] b,
			input int sh);
		logic signed [63:0] p;
		p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
		p = p >>> sh;
		return p[31:0];
	endfunction

	function automatic rsp_t quotient(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ma, mb;
		logic [63:0] q;
		rsp_t r;
		ma = magnitude(a);
		mb = magnitude(b);
		if ((ma >> GUARD_SHIFT) >= mb) begin
			r.saturated = 1'b1;
			r.result = (a[31] ^ b[31]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			r.saturated = 1'b0;
			q = ({32'd0, ma} << FRAC_BITS) / {32'd0, mb};
			if (a[31] ^ b[31])
				q = 64'd0 - q;
			r.result = q[31:0];
		end
		return r;
	endfunction

	function automatic rsp_t compute(input req_t r);
		rsp_t o;
		o.saturated = 1'b0;
		case (op_t'(r.req_type))
			OP_MUL:   o.result = product_shift(r.operand_a, r.operand_b, FRAC_BITS);
			OP_MULSH: o.result = product_shift(r.operand_a, r.operand_b, r.shift_amount);
			OP_DIV:   o = quotient(r.operand_a, r.operand_b);
			default:  o = quotient(product_shift(r.operand_a, r.operand_b, FRAC_BITS),
					r.operand_c);
		endcase
		return o;
	endfunction

	class result_board;
		rsp_t pending[$];

		function void note_request(req_t r);
			pending.push_back(compute(r));
		endfunction

		task check_result(rsp_t got);
			rsp_t exp;
			if (pending.size() == 0) begin
				report("unexpected result", got.result, 32'd0);
				return;
			end
			exp = pending.pop_front();
			if (got.result !== exp.result)
				report("result", got.result, exp.result);
			if (got.saturated !== exp.saturated)
				report("saturated", {31'd0, got.saturated}, {31'd0, exp.saturated});
		endtask
	endclass

	result_board board = new();

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				board.note_request(req.data);
			if (rsp.valid && rsp.ready)
				board.check_result(rsp.data);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WD_LIMIT) begin
				$display("watchdog expired");
				$display("fixed_point_mul_div_tb NOT OK");
				$finish;
			end
		end
	end

	// response side: random stalls in bursts, plus one long hold-off
	initial begin
		int n;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_rsp) begin
				rsp.ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_rsp = 1'b0;
			end else if (!no_idle && $urandom_range(0, 3) == 0) begin
				rsp.ready <= 1'b0;
				n = $urandom_range(1, 15);
				repeat (n) @(posedge clk);
			end else begin
				rsp.ready <= 1'b1;
				n = $urandom_range(1, 20);
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic send(input req_t r);
		int n;
		if (!no_idle && $urandom_range(0, 9) == 0) begin
			req.valid <= 1'b0;
			n = $urandom_range(1, 15);
			repeat (n) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= r;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	task automatic send_ops(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
			input logic [5:0] sh, input op_t op);
		req_t r;
		r.req_type = op;
		r.operand_a = a;
		r.operand_b = b;
		r.operand_c = c;
		r.shift_amount = sh;
		send(r);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'd0;
			3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
			4: return $urandom_range(0, 1) ? $urandom_range(0, 255) : -$urandom_range(0, 255);
			5: return $signed($urandom()) >>> $urandom_range(0, 24);
			default: return $urandom();
		endcase
	endfunction

	initial begin
		req_t r;
		req.valid = 1'b0;
		req.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send_ops(32'h8000_0000, 32'h8000_0000, 32'd1, 6'd0, OP_MUL);
		send_ops(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 6'd0, OP_MUL);
		send_ops(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 6'd0, OP_MULSH);
		send_ops(32'h8000_0000, 32'h8000_0000, 32'd1, 6'd63, OP_MULSH);
		send_ops(32'hFFFF_FFFF, 32'h0000_0001, 32'd1, 6'd63, OP_MULSH);
		send_ops(32'h1234_5678, 32'h9ABC_DEF0, 32'd1, 6'd32, OP_MULSH);
		send_ops(32'h0001_0000, 32'd0, 32'd0, 6'd0, OP_DIV);
		send_ops(32'hFFFF_0000, 32'd0, 32'd0, 6'd0, OP_DIV);
		send_ops(32'h8000_0000, 32'h8000_0000, 32'd0, 6'd0, OP_DIV);
		send_ops(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 6'd0, OP_DIV);
		send_ops(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 6'd0, OP_DIV);
		send_ops(32'h0003_FFFF, 32'h0000_0001, 32'd0, 6'd0, OP_DIV);
		send_ops(32'h0004_0000, 32'h0000_0001, 32'd0, 6'd0, OP_DIV);
		send_ops(32'hFFFB_FFFF, 32'h0000_0002, 32'd0, 6'd0, OP_DIV);
		send_ops(32'h0001_0000, 32'h0003_0000, 32'd0, 6'd0, OP_DIV);
		send_ops(32'h0002_0000, 32'h0003_0000, 32'h0000_0000, 6'd0, OP_SCALE);
		send_ops(32'h0002_0000, 32'h0003_0000, 32'hFFF9_0000, 6'd0, OP_SCALE);
		send_ops(32'h8000_0000, 32'h0001_0000, 32'h8000_0000, 6'd0, OP_SCALE);
		send_ops(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'h3F, OP_SCALE);
		drain();

		// long output hold-off while requests keep coming, to fill the queue
		hold_rsp = 1'b1;
		for (int i = 0; i < 80; i++) begin
			r = req_t'({8'($urandom()), $urandom(), $urandom(), $urandom()});
			send(r);
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - 300)
				no_idle = 1'b1;
			if (i == N_RANDOM / 2)
				drain();
			r.req_type = 2'($urandom_range(0, 3));
			r.operand_a = pick_operand();
			r.operand_b = pick_operand();
			r.operand_c = pick_operand();
			r.shift_amount = 6'($urandom_range(0, 63));
			send(r);
		end
		req.valid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (n_err == 0 && board.pending.size() == 0)
			$display("fixed_point_mul_div_tb OK");
		else
			$display("fixed_point_mul_div_tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
